### hw/rtl/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int DATA_W       = 32;
    localparam int MODE_W       = 3;
    localparam int POS_W        = 7;
    localparam int COUNT_W      = 7;
    localparam int STATUS_W     = 2;
    localparam int TDATA_W      = 48;

    // request modes; codes five to seven do nothing
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

endpackage

### hw/rtl/ple_store.sv
module ple_store #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(ple_pkg::CAPACITY_DEF)
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [ple_pkg::DATA_W-1:0]  wr_data,
    input  logic [AW-1:0]               rd_addr,
    output logic [ple_pkg::DATA_W-1:0]  rd_data
);

    logic [ple_pkg::DATA_W-1:0] mem [DEPTH];
    logic [ple_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/positional_list_engine_top.sv
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// values in a single-port-write, single-port-read memory, driven by a small
// sequencer. Each item on the slave stream is one request (insert, remove,
// read, overwrite, clear) and yields exactly one item on the master stream
// with the value read, the new count, an empty flag and a status. Insert and
// remove move the tail of the list one entry at a time through the memory,
// each moved entry being read, then written back one place over. The memory
// port is the limit. s_tready is high only while the sequencer is idle; a
// finished result sits in the output register, so a new item is taken even
// while the previous result waits for m_tready. A rejected request (bad
// position, or insert into a full list) leaves the list untouched.
module positional_list_engine_top #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // request stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ple_pkg::TDATA_W-1:0]  s_tdata,   // mode[2:0], position[9:3], value[41:10]
    // result stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ple_pkg::TDATA_W-1:0]  m_tdata    // read_value[31:0], count[38:32],
                                                    // is_empty[39], status[41:40]
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,  // waiting for a request
        ST_RD   = 4'b0010,  // read source entry
        ST_WR   = 4'b0100,  // write it one place over
        ST_FIN  = 4'b1000   // commit and present result
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [ple_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [ple_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [ple_pkg::STATUS_W-1:0] status_reg, status_next;

    // shift cursor (destination of the current move) and list length
    logic [AW-1:0]                idx_reg, idx_next;
    logic [CW-1:0]                count_reg, count_next;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [ple_pkg::TDATA_W-1:0]  m_data_reg, m_data_next;

    // request fields
    logic [ple_pkg::MODE_W-1:0]   in_mode;
    logic [ple_pkg::POS_W-1:0]    in_pos;
    logic [ple_pkg::DATA_W-1:0]   in_val;
    logic [CMPW-1:0]              pos_x, cnt_x;

    // memory port
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr, mem_raddr;
    logic [ple_pkg::DATA_W-1:0]   mem_wdata, mem_rdata;

    logic                         accept, out_free, op_ok;
    logic [AW-1:0]                idx_dec, idx_inc, last_src;
    logic [ple_pkg::DATA_W-1:0]   rd_value;

    assign in_mode = s_tdata[2:0];
    assign in_pos  = s_tdata[9:3];
    assign in_val  = s_tdata[41:10];
    assign pos_x   = CMPW'(in_pos);
    assign cnt_x   = CMPW'(count_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign op_ok    = (status_reg == ple_pkg::STATUS_OK);

    assign idx_dec  = idx_reg - AW'(1);
    assign idx_inc  = idx_reg + AW'(1);
    // last destination of a remove shift is count-2
    assign last_src = AW'(count_reg - CW'(1));

    // source of a move: one below for insert, one above for remove
    always_comb begin
        case (mode_reg)
            ple_pkg::MODE_INSERT: mem_raddr = idx_dec;
            ple_pkg::MODE_REMOVE: mem_raddr = idx_inc;
            default:              mem_raddr = idx_reg;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg;
        mem_wdata    = val_reg;
        rd_value     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next   = in_mode;
                    pos_next    = AW'(in_pos);
                    val_next    = in_val;
                    status_next = ple_pkg::STATUS_OK;
                    idx_next    = AW'(in_pos);
                    state_next  = ST_FIN;
                    case (in_mode)
                        ple_pkg::MODE_INSERT: begin
                            idx_next = AW'(count_reg);
                            if (pos_x > cnt_x) begin
                                status_next = ple_pkg::STATUS_BADPOS;
                            end else if (count_reg == CW'(CAPACITY)) begin
                                status_next = ple_pkg::STATUS_FULL;
                            end else if (pos_x != cnt_x) begin
                                state_next = ST_RD;
                            end
                        end
                        ple_pkg::MODE_REMOVE: begin
                            if (pos_x >= cnt_x) begin
                                status_next = ple_pkg::STATUS_BADPOS;
                            end else if (CMPW'(pos_x + CMPW'(1)) != cnt_x) begin
                                state_next = ST_RD;
                            end
                        end
                        ple_pkg::MODE_READ: begin
                            if (pos_x >= cnt_x) begin
                                status_next = ple_pkg::STATUS_BADPOS;
                            end else begin
                                state_next = ST_RD;
                            end
                        end
                        ple_pkg::MODE_OVERWRITE: begin
                            if (pos_x >= cnt_x) begin
                                status_next = ple_pkg::STATUS_BADPOS;
                            end
                        end
                        default: begin
                            // clear and unused modes finish directly
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = (mode_reg == ple_pkg::MODE_READ) ? ST_FIN : ST_WR;
            end
            ST_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                if (mode_reg == ple_pkg::MODE_INSERT) begin
                    idx_next   = idx_dec;
                    state_next = (idx_dec == pos_reg) ? ST_FIN : ST_RD;
                end else begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == last_src) ? ST_FIN : ST_RD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    if (op_ok) begin
                        case (mode_reg)
                            ple_pkg::MODE_INSERT: begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            ple_pkg::MODE_REMOVE: begin
                                count_next = count_reg - CW'(1);
                            end
                            ple_pkg::MODE_READ: begin
                                rd_value = mem_rdata;
                            end
                            ple_pkg::MODE_OVERWRITE: begin
                                mem_we = 1'b1;
                            end
                            ple_pkg::MODE_CLEAR: begin
                                count_next = '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, status_reg, (count_next == '0),
                                    ple_pkg::COUNT_W'(count_next), rd_value};
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
    end

    ple_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // list never grows past capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
    else $error("list count above capacity");

    // an accepted item always leaves idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != ST_IDLE))
    else $error("accepted item did not start");

    // insert shift stays strictly above the insert position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR && mode_reg == ple_pkg::MODE_INSERT) |-> (idx_reg > pos_reg))
    else $error("insert shift passed its position");

    // full status only reported when the list is at capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && status_reg == ple_pkg::STATUS_FULL)
            |-> (count_reg == CW'(CAPACITY)))
    else $error("full status with room left");

    // memory writes only from the shift or commit steps
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_WR || state_reg == ST_FIN))
    else $error("stray memory write");

endmodule

### bench/positional_list_engine_top_tb.sv
`timescale 1ns / 1ps

module positional_list_engine_top_tb;

    localparam int LIST_CAPACITY = ple_pkg::CAPACITY_DEF;
    localparam int POS_MAX       = 2**ple_pkg::POS_W - 1;
    // worst single item: insert at the front of an almost full list
    localparam int LONGEST_ITEM  = 2 * LIST_CAPACITY + 8;

    typedef logic [ple_pkg::MODE_W-1:0] mode_t;
    typedef logic [ple_pkg::POS_W-1:0]  pos_t;

    // mode codes the block treats as no-ops
    localparam mode_t MODE_UNUSED_FIRST = 3'd5;
    localparam mode_t MODE_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [ple_pkg::DATA_W-1:0]   read_value;
        logic [ple_pkg::COUNT_W-1:0]  count;
        logic                         is_empty;
        logic [ple_pkg::STATUS_W-1:0] status;
    } list_result_t;

    logic                        aclk;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [ple_pkg::TDATA_W-1:0] s_tdata;   // mode[2:0], position[9:3], value[41:10]
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [ple_pkg::TDATA_W-1:0] m_tdata;   // read_value[31:0], count[38:32],
                                            // is_empty[39], status[41:40]

    // shadow copy of the list, updated as each item is accepted
    logic [ple_pkg::DATA_W-1:0]  shadow_list [LIST_CAPACITY];
    int                          shadow_len;

    list_result_t       expected_results [$];
    int                 mismatch_count;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    positional_list_engine_top #(
        .CAPACITY (LIST_CAPACITY)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Generous cap: every item at its longest shift plus long receiver stalls.
    initial begin
        #24_000_000;
        $display("Timeout: %0d results still outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

    // Applies one request to the shadow list and returns the result it must give.
    // Position is checked before the full condition on insert.
    function automatic list_result_t predict_list_result(
        input mode_t                      mode,
        input pos_t                       pos,
        input logic [ple_pkg::DATA_W-1:0] val
    );
        list_result_t r;
        int           k;
        r.read_value = '0;
        r.status     = ple_pkg::STATUS_OK;
        case (mode)
            ple_pkg::MODE_INSERT: begin
                if (pos > shadow_len) begin
                    r.status = ple_pkg::STATUS_BADPOS;
                end else if (shadow_len >= LIST_CAPACITY) begin
                    r.status = ple_pkg::STATUS_FULL;
                end else begin
                    for (k = shadow_len; k > pos; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[pos] = val;
                    shadow_len++;
                end
            end
            ple_pkg::MODE_REMOVE: begin
                if (pos >= shadow_len) begin
                    r.status = ple_pkg::STATUS_BADPOS;
                end else begin
                    for (k = pos; k + 1 < shadow_len; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_len--;
                end
            end
            ple_pkg::MODE_READ: begin
                if (pos >= shadow_len)
                    r.status = ple_pkg::STATUS_BADPOS;
                else
                    r.read_value = shadow_list[pos];
            end
            ple_pkg::MODE_OVERWRITE: begin
                if (pos >= shadow_len)
                    r.status = ple_pkg::STATUS_BADPOS;
                else
                    shadow_list[pos] = val;
            end
            ple_pkg::MODE_CLEAR: begin
                shadow_len = 0;
            end
            default: begin
            end
        endcase
        r.count    = shadow_len[ple_pkg::COUNT_W-1:0];
        r.is_empty = (shadow_len == 0);
        return r;
    endfunction

    // Sender: optional random gap, then hold the item until the handshake.
    // Called and returns at a falling edge; valid stays high so back-to-back
    // items do not glitch it.
    task automatic send_request(
        input mode_t                      mode,
        input pos_t                       pos,
        input logic [ple_pkg::DATA_W-1:0] val
    );
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {{(ple_pkg::TDATA_W - ple_pkg::DATA_W - ple_pkg::POS_W
                      - ple_pkg::MODE_W){1'b0}}, val, pos, mode};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_list_result(mode, pos, val));
        @(negedge aclk);
    endtask

    // Sender holds off until every outstanding result has been taken.
    task automatic wait_for_results();
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic check_field(
        input string       name,
        input logic [31:0] exp_v,
        input logic [31:0] act_v
    );
        if (act_v !== exp_v) begin
            mismatch_count++;
            $display("%0t: %s differs, expected %h actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Receiver: random backpressure, changed on the falling edge.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Result checker: every accepted item is matched against the oldest prediction.
    always @(posedge aclk) begin : result_check
        list_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, expected nothing actual %h",
                         $time, m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                check_field("read_value", exp_r.read_value, m_tdata[31:0]);
                check_field("count", 32'(exp_r.count), 32'(m_tdata[38:32]));
                check_field("is_empty", 32'(exp_r.is_empty), 32'(m_tdata[39]));
                check_field("status", 32'(exp_r.status), 32'(m_tdata[41:40]));
            end
        end
    end

    // Hand-picked items: field extremes, every mode, each bad-position path,
    // front insert into a non-empty list, removing the only entry.
    task automatic test_directed_cases();
        send_request(ple_pkg::MODE_READ, 0, 32'h1234_5678);     // empty list: bad position
        send_request(ple_pkg::MODE_REMOVE, 0, 32'h0);
        send_request(ple_pkg::MODE_OVERWRITE, 0, 32'hFFFF_FFFF);
        send_request(ple_pkg::MODE_INSERT, 1, 32'h1);            // past the end of empty list
        send_request(ple_pkg::MODE_INSERT, 0, 32'h7FFF_FFFF);
        send_request(ple_pkg::MODE_INSERT, 0, 32'h8000_0000);    // front of non-empty list
        send_request(ple_pkg::MODE_INSERT, 2, 32'hFFFF_FFFF);    // append
        send_request(ple_pkg::MODE_INSERT, 4, 32'h5555_5555);    // past the end
        send_request(ple_pkg::MODE_INSERT, pos_t'(POS_MAX), 32'h0); // top position code
        send_request(ple_pkg::MODE_READ, 0, 32'h0);
        send_request(ple_pkg::MODE_READ, 1, 32'hFFFF_FFFF);
        send_request(ple_pkg::MODE_READ, 2, 32'h0);
        send_request(ple_pkg::MODE_READ, 3, 32'h0);              // one past the last entry
        send_request(ple_pkg::MODE_OVERWRITE, 1, 32'h0);
        send_request(ple_pkg::MODE_READ, 1, 32'hAAAA_AAAA);
        send_request(ple_pkg::MODE_OVERWRITE, 3, 32'h1);
        send_request(MODE_UNUSED_FIRST, pos_t'(POS_MAX), 32'hFFFF_FFFF);
        send_request(MODE_UNUSED_FIRST + 3'd1, 0, 32'h0);
        send_request(MODE_UNUSED_LAST, 1, 32'h8000_0000);
        send_request(ple_pkg::MODE_REMOVE, 0, 32'h0);
        send_request(ple_pkg::MODE_REMOVE, 2, 32'h0);            // out of range
        send_request(ple_pkg::MODE_REMOVE, 1, 32'h0);
        send_request(ple_pkg::MODE_REMOVE, 0, 32'h0);            // only entry
        send_request(ple_pkg::MODE_INSERT, 0, 32'h0000_0001);
        send_request(ple_pkg::MODE_CLEAR, pos_t'(POS_MAX), 32'hFFFF_FFFF); // clear non-empty
        wait_for_results();
    endtask

    // Fill to capacity from mixed positions, hit the full and bad-position
    // paths at the limit, then drain by removes at random places.
    task automatic test_fill_to_capacity();
        pos_t pos;
        int   i;
        send_request(ple_pkg::MODE_CLEAR, 0, $urandom());
        for (i = 0; i < LIST_CAPACITY; i++) begin
            case (i % 3)
                0: pos = 0;
                1: pos = pos_t'(shadow_len);
                default: pos = pos_t'($urandom_range(shadow_len));
            endcase
            send_request(ple_pkg::MODE_INSERT, pos, $urandom());
        end
        send_request(ple_pkg::MODE_INSERT, 0, $urandom());                        // full
        send_request(ple_pkg::MODE_INSERT, pos_t'(LIST_CAPACITY), $urandom());    // full
        // position wins over full
        send_request(ple_pkg::MODE_INSERT, pos_t'(LIST_CAPACITY + 1), $urandom());
        send_request(ple_pkg::MODE_READ, pos_t'(LIST_CAPACITY - 1), $urandom());
        send_request(ple_pkg::MODE_READ, pos_t'(LIST_CAPACITY), $urandom());
        send_request(ple_pkg::MODE_OVERWRITE, pos_t'(LIST_CAPACITY - 1), $urandom());
        send_request(ple_pkg::MODE_READ, pos_t'(LIST_CAPACITY - 1), $urandom());
        while (shadow_len > 0) begin
            pos = pos_t'($urandom_range(shadow_len - 1));
            if ($urandom_range(3) == 0)
                send_request(ple_pkg::MODE_READ, pos, $urandom());
            send_request(ple_pkg::MODE_REMOVE, pos, $urandom());
        end
        send_request(ple_pkg::MODE_READ, 0, $urandom());
        wait_for_results();
    endtask

    // Mostly well-formed requests (valid positions, insert-heavy so the list
    // reaches full), with a tenth of pure noise over every mode and position code.
    task automatic test_random_requests(input int n_items);
        mode_t mode;
        pos_t  pos;
        int    pick;
        repeat (n_items) begin
            if ($urandom_range(99) < 10) begin
                mode = mode_t'($urandom_range(MODE_UNUSED_LAST));
                pos  = pos_t'($urandom_range(POS_MAX));
            end else begin
                pick = $urandom_range(999);
                if (pick < 5)
                    mode = ple_pkg::MODE_CLEAR;
                else if (pick < 400)
                    mode = ple_pkg::MODE_INSERT;
                else if (pick < 600)
                    mode = ple_pkg::MODE_REMOVE;
                else if (pick < 800)
                    mode = ple_pkg::MODE_READ;
                else if (pick < 980)
                    mode = ple_pkg::MODE_OVERWRITE;
                else
                    mode = mode_t'(MODE_UNUSED_FIRST
                         + $urandom_range(MODE_UNUSED_LAST - MODE_UNUSED_FIRST));
                if (mode == ple_pkg::MODE_INSERT)
                    pos = pos_t'($urandom_range(shadow_len));
                else if (shadow_len > 0)
                    pos = pos_t'($urandom_range(shadow_len - 1));
                else
                    pos = 0;
            end
            send_request(mode, pos, $urandom());
            if ($urandom_range(99) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        shadow_len     = 0;
        mismatch_count = 0;
        send_idle_pct  = 33;
        recv_idle_pct  = 85;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // slow receiver
        test_directed_cases();
        test_random_requests(400);

        // slow sender
        send_idle_pct = 85;
        recv_idle_pct = 33;
        test_fill_to_capacity();
        test_random_requests(350);

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_requests(400);
        test_fill_to_capacity();

        // any stray result would show up within one longest item
        wait_for_results();
        repeat (LONGEST_ITEM) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ple_pkg.sv
hw/rtl/ple_store.sv
hw/rtl/positional_list_engine_top.sv
bench/positional_list_engine_top_tb.sv
